// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the walking pattern step RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lwps_pkg.sv =====
// Package for the walking pattern step core: payload types, opcodes,
// register file map and the sequencer microprogram. No dependencies.
`timescale 1ns / 1ps
package lwps_pkg;

  localparam int unsigned MaxSamples = 64;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] step_length;
    logic signed [31:0] step_width;
    logic signed [31:0] next_length;
    logic signed [31:0] next_width;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] com_x;
    logic signed [31:0] com_y;
    logic               last_sample;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] landing_x;
    logic signed [31:0] landing_y;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_ADDP, OP_MUL, OP_WMUL, OP_DIV, OP_HALF, OP_NEG, OP_NEGP,
    OP_PASS, OP_ONE, OP_IN, OP_BRZ, OP_LOOP, OP_EMIT, OP_STAGE, OP_LAST
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] dst;
    logic [5:0] a;
    logic [5:0] b;
    logic [6:0] imm;
  } insn_t;

  typedef struct packed {
    logic start;
    op_e  op;
    logic parity;
  } alu_req_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_TC = 3'd0, CFG_SC = 3'd1, CFG_SS = 3'd2, CFG_UC = 3'd3,
                         CFG_US = 3'd4, CFG_WP = 3'd5, CFG_WV = 3'd6, CFG_NS = 3'd7;

  // Register file map: configuration copies first, then state, then temporaries
  localparam logic [5:0] R_TC = 6'd0, R_SC = 6'd1, R_SS = 6'd2, R_UC = 6'd3,
                         R_US = 6'd4, R_WP = 6'd5, R_WV = 6'd6;
  localparam logic [5:0] R_SPX = 6'd7, R_SPY = 6'd8, R_SVX = 6'd9, R_SVY = 6'd10,
                         R_NFX = 6'd11, R_NFY = 6'd12, R_MFX = 6'd13, R_MFY = 6'd14;
  localparam logic [5:0] R_RX = 6'd15, R_RY = 6'd16, R_T0 = 6'd17, R_T1 = 6'd18,
                         R_T2 = 6'd19, R_TCS = 6'd20, R_SOT = 6'd21, R_XB = 6'd22,
                         R_YB = 6'd23, R_KS = 6'd24, R_CM1 = 6'd25, R_KX = 6'd26,
                         R_KY = 6'd27, R_TGX = 6'd28, R_VTX = 6'd29, R_TGY = 6'd30,
                         R_VTY = 6'd31, R_SOT2 = 6'd32, R_D = 6'd33, R_G1 = 6'd34,
                         R_G2 = 6'd35;
  localparam logic signed [31:0] StartPosYReset = 32'sd655;

  localparam logic [6:0] PC_LOOP = 7'd4;
  localparam logic [6:0] PC_POS = 7'd19;

  // Saturate a wide value to Q16.16 range
  function automatic logic signed [31:0] qsat(logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return QMax;
    if (v < -64'sh0000_0000_8000_0000) return QMin;
    return v[31:0];
  endfunction

  function automatic insn_t mk(op_e op, logic [5:0] d, logic [5:0] a, logic [5:0] b,
                               logic [6:0] imm);
    insn_t i;
    i.op = op; i.dst = d; i.a = a; i.b = b; i.imm = imm;
    return i;
  endfunction

  // Microprogram for one footstep
  function automatic insn_t prog(logic [6:0] pc);
    case (pc)
      7'd0:  return mk(OP_MUL, R_TCS, R_TC, R_SS, '0);
      7'd1:  return mk(OP_DIV, R_SOT, R_SS, R_TC, '0);
      7'd2:  return mk(OP_SUB, R_RX, R_SPX, R_MFX, '0);
      7'd3:  return mk(OP_SUB, R_RY, R_SPY, R_MFY, '0);
      // sample loop: first sample skips the recurrence
      7'd4:  return mk(OP_BRZ, '0, '0, '0, PC_POS);
      7'd5:  return mk(OP_MUL, R_T0, R_SC, R_RX, '0);
      7'd6:  return mk(OP_MUL, R_T1, R_TCS, R_SVX, '0);
      7'd7:  return mk(OP_ADD, R_T2, R_T0, R_T1, '0);
      7'd8:  return mk(OP_MUL, R_T0, R_SOT, R_RX, '0);
      7'd9:  return mk(OP_MUL, R_T1, R_SC, R_SVX, '0);
      7'd10: return mk(OP_ADD, R_SVX, R_T0, R_T1, '0);
      7'd11: return mk(OP_PASS, R_RX, R_T2, '0, '0);
      7'd12: return mk(OP_MUL, R_T0, R_SC, R_RY, '0);
      7'd13: return mk(OP_MUL, R_T1, R_TCS, R_SVY, '0);
      7'd14: return mk(OP_ADD, R_T2, R_T0, R_T1, '0);
      7'd15: return mk(OP_MUL, R_T0, R_SOT, R_RY, '0);
      7'd16: return mk(OP_MUL, R_T1, R_SC, R_SVY, '0);
      7'd17: return mk(OP_ADD, R_SVY, R_T0, R_T1, '0);
      7'd18: return mk(OP_PASS, R_RY, R_T2, '0, '0);
      7'd19: return mk(OP_ADD, R_SPX, R_RX, R_MFX, '0);
      7'd20: return mk(OP_ADD, R_SPY, R_RY, R_MFY, '0);
      7'd21: return mk(OP_EMIT, '0, R_SPX, R_SPY, '0);
      7'd22: return mk(OP_LOOP, '0, '0, '0, PC_LOOP);
      // nominal foot point and walk primitive target
      7'd23: return mk(OP_IN, R_T0, '0, '0, 7'd0);
      7'd24: return mk(OP_ADD, R_NFX, R_NFX, R_T0, '0);
      7'd25: return mk(OP_IN, R_T0, '0, '0, 7'd1);
      7'd26: return mk(OP_ADDP, R_NFY, R_NFY, R_T0, '0);
      7'd27: return mk(OP_IN, R_T0, '0, '0, 7'd2);
      7'd28: return mk(OP_HALF, R_XB, R_T0, '0, '0);
      7'd29: return mk(OP_IN, R_T0, '0, '0, 7'd3);
      7'd30: return mk(OP_HALF, R_T1, R_T0, '0, '0);
      7'd31: return mk(OP_NEGP, R_YB, R_T1, '0, '0);
      7'd32: return mk(OP_MUL, R_KS, R_TC, R_US, '0);
      7'd33: return mk(OP_ONE, R_T0, '0, '0, '0);
      7'd34: return mk(OP_ADD, R_T1, R_UC, R_T0, '0);
      7'd35: return mk(OP_DIV, R_KX, R_T1, R_KS, '0);
      7'd36: return mk(OP_SUB, R_CM1, R_UC, R_T0, '0);
      7'd37: return mk(OP_DIV, R_KY, R_CM1, R_KS, '0);
      7'd38: return mk(OP_ADD, R_TGX, R_NFX, R_XB, '0);
      7'd39: return mk(OP_MUL, R_VTX, R_KX, R_XB, '0);
      7'd40: return mk(OP_ADD, R_TGY, R_NFY, R_YB, '0);
      7'd41: return mk(OP_MUL, R_VTY, R_KY, R_YB, '0);
      // landing gains
      7'd42: return mk(OP_DIV, R_SOT2, R_US, R_TC, '0);
      7'd43: return mk(OP_MUL, R_T0, R_CM1, R_CM1, '0);
      7'd44: return mk(OP_WMUL, R_T0, R_WP, R_T0, '0);
      7'd45: return mk(OP_MUL, R_T1, R_SOT2, R_SOT2, '0);
      7'd46: return mk(OP_WMUL, R_T1, R_WV, R_T1, '0);
      7'd47: return mk(OP_ADD, R_D, R_T0, R_T1, '0);
      7'd48: return mk(OP_WMUL, R_T0, R_WP, R_CM1, '0);
      7'd49: return mk(OP_DIV, R_G1, R_T0, R_D, '0);
      7'd50: return mk(OP_WMUL, R_T0, R_WV, R_SOT2, '0);
      7'd51: return mk(OP_DIV, R_G2, R_T0, R_D, '0);
      // forward landing point
      7'd52: return mk(OP_MUL, R_T0, R_UC, R_SPX, '0);
      7'd53: return mk(OP_SUB, R_T1, R_TGX, R_T0, '0);
      7'd54: return mk(OP_MUL, R_T0, R_KS, R_SVX, '0);
      7'd55: return mk(OP_SUB, R_T1, R_T1, R_T0, '0);
      7'd56: return mk(OP_MUL, R_T0, R_SOT2, R_SPX, '0);
      7'd57: return mk(OP_SUB, R_T2, R_VTX, R_T0, '0);
      7'd58: return mk(OP_MUL, R_T0, R_UC, R_SVX, '0);
      7'd59: return mk(OP_SUB, R_T2, R_T2, R_T0, '0);
      7'd60: return mk(OP_MUL, R_T0, R_G1, R_T1, '0);
      7'd61: return mk(OP_NEG, R_T0, R_T0, '0, '0);
      7'd62: return mk(OP_MUL, R_T1, R_G2, R_T2, '0);
      7'd63: return mk(OP_SUB, R_MFX, R_T0, R_T1, '0);
      // sideways landing point
      7'd64: return mk(OP_MUL, R_T0, R_UC, R_SPY, '0);
      7'd65: return mk(OP_SUB, R_T1, R_TGY, R_T0, '0);
      7'd66: return mk(OP_MUL, R_T0, R_KS, R_SVY, '0);
      7'd67: return mk(OP_SUB, R_T1, R_T1, R_T0, '0);
      7'd68: return mk(OP_MUL, R_T0, R_SOT2, R_SPY, '0);
      7'd69: return mk(OP_SUB, R_T2, R_VTY, R_T0, '0);
      7'd70: return mk(OP_MUL, R_T0, R_UC, R_SVY, '0);
      7'd71: return mk(OP_SUB, R_T2, R_T2, R_T0, '0);
      7'd72: return mk(OP_MUL, R_T0, R_G1, R_T1, '0);
      7'd73: return mk(OP_NEG, R_T0, R_T0, '0, '0);
      7'd74: return mk(OP_MUL, R_T1, R_G2, R_T2, '0);
      7'd75: return mk(OP_SUB, R_MFY, R_T0, R_T1, '0);
      // final sample with foot and landing points
      7'd76: return mk(OP_STAGE, '0, R_NFX, R_NFY, 7'd0);
      7'd77: return mk(OP_STAGE, '0, R_MFX, R_MFY, 7'd1);
      7'd78: return mk(OP_LAST, '0, R_SPX, R_SPY, '0);
      default: return mk(OP_LAST, '0, R_SPX, R_SPY, '0);
    endcase
  endfunction

endpackage

// ===== rtl/core/lwps_alu.sv =====
// Shared Q16.16 arithmetic unit: saturating add/sub, multiply, weight
// multiply and a bit-serial rounding divider. Depends on lwps_pkg.
`timescale 1ns / 1ps
module lwps_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lwps_pkg::alu_req_t      req_i,
  input  logic signed [31:0]      a_i,
  input  logic signed [31:0]      b_i,
  output logic                    done_o,
  output logic signed [31:0]      res_o
);
  import lwps_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL2, A_DIV} alu_state_e;

  alu_state_e         state_q;
  logic               done_q;
  logic signed [31:0] res_q;
  logic signed [63:0] prod_q;
  logic               mulw_q;
  logic [48:0]        dv_q;
  logic [31:0]        ud_q;
  logic [31:0]        rem_q;
  logic [5:0]         cnt_q;
  logic               neg_q;

  logic signed [63:0] ax, bx;
  logic [31:0]        abs_a, abs_b;
  logic [32:0]        shifted;
  logic               qbit;
  logic [48:0]        qv;

  assign ax = 64'(a_i);
  assign bx = 64'(b_i);
  assign abs_a = a_i[31] ? 32'(-ax) : 32'(a_i);
  assign abs_b = b_i[31] ? 32'(-bx) : 32'(b_i);

  // one restoring division step
  assign shifted = {rem_q, dv_q[48]};
  assign qbit = (shifted >= {1'b0, ud_q});
  assign qv = {dv_q[47:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              OP_ADD: begin res_q <= qsat(ax + bx); done_q <= 1'b1; end
              OP_SUB: begin res_q <= qsat(ax - bx); done_q <= 1'b1; end
              OP_ADDP: begin
                res_q  <= req_i.parity ? qsat(ax - bx) : qsat(ax + bx);
                done_q <= 1'b1;
              end
              OP_HALF: begin res_q <= a_i >>> 1; done_q <= 1'b1; end
              OP_NEG: begin res_q <= qsat(-ax); done_q <= 1'b1; end
              OP_NEGP: begin
                res_q  <= req_i.parity ? a_i : qsat(-ax);
                done_q <= 1'b1;
              end
              OP_MUL, OP_WMUL: begin
                prod_q  <= ax * bx;
                mulw_q  <= (req_i.op == OP_WMUL);
                state_q <= A_MUL2;
              end
              OP_DIV: begin
                if (b_i == 32'sd0) begin
                  // divide by zero saturates by numerator sign, or gives zero for a zero numerator
                  res_q  <= (a_i == 32'sd0) ? 32'sd0 : (a_i[31] ? QMin : QMax);
                  done_q <= 1'b1;
                end else begin
                  dv_q    <= {1'b0, abs_a, 16'h0000} + 49'(abs_b >> 1);
                  ud_q    <= abs_b;
                  rem_q   <= '0;
                  cnt_q   <= '0;
                  neg_q   <= a_i[31] ^ b_i[31];
                  state_q <= A_DIV;
                end
              end
              default: begin res_q <= a_i; done_q <= 1'b1; end
            endcase
          end
        end
        A_MUL2: begin
          res_q   <= mulw_q ? qsat(prod_q) : qsat((prod_q + 64'sd32768) >>> 16);
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        A_DIV: begin
          rem_q <= qbit ? 32'(shifted - {1'b0, ud_q}) : shifted[31:0];
          dv_q  <= qv;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd48) begin
            // quotient complete: apply sign and saturate
            if (neg_q) begin
              res_q <= (qv > 49'h0_8000_0000) ? QMin : 32'(-qv[31:0]);
            end else begin
              res_q <= (qv > 49'h0_7FFF_FFFF) ? QMax : qv[31:0];
            end
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/lip_walking_pattern_step_core.sv =====
// Footsteps are taken one at a time: a new footstep is accepted only after the
// previous one has loaded its final sample; a divide by zero finishes early. Each
// instruction passes S_FETCH and S_EXEC; arithmetic ones then wait in S_WAIT.
// Shared unit: multiply passes A_MUL2, divide runs bit-serially in A_DIV.
// Reset: a pass over the register file loads it; no footstep is taken until it ends.
// Top level: APB registers, microcode sequencer and register file.
// Depends on lwps_pkg, lwps_alu and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lip_walking_pattern_step_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lwps_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lwps_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lwps_pkg::*;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_FETCH, S_EXEC, S_WAIT} seq_state_e;

  // configuration shadow registers
  logic [30:0] tc_q, sc_q, ss_q, uc_q, us_q;
  logic [15:0] wp_q, wv_q;
  logic [6:0]  ns_q;

  seq_state_e         state_q;
  logic [6:0]         pc_q;
  logic [5:0]         k_q;
  logic [6:0]         n_q;
  logic               parity_q;
  logic [5:0]         init_q;
  in_item_t           in_q;
  out_item_t          out_q;
  logic               out_valid_q;
  logic signed [31:0] stage_q [4];

  logic signed [31:0] mem [64];
  logic signed [31:0] rd_a_q, rd_b_q;

  insn_t              ins;
  alu_req_t           alu_req;
  logic               alu_done;
  logic signed [31:0] alu_res;
  logic               apb_we;
  logic [2:0]         cfg_idx;
  logic               we;
  logic [5:0]         wa;
  logic signed [31:0] wd;
  logic signed [31:0] init_data;
  logic signed [31:0] in_field;
  logic               out_free;
  logic               out_load;
  logic               k_last;
  logic               is_alu_op;

  assign ins      = prog(pc_q);
  assign apb_we   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];
  assign pready   = 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign k_last   = ({1'b0, k_q} + 7'd1) == n_q;
  assign out_load = (state_q == S_EXEC) && out_free &&
                    (((ins.op == OP_EMIT) && !k_last) || (ins.op == OP_LAST));
  assign is_alu_op = (ins.op == OP_ADD) || (ins.op == OP_SUB) || (ins.op == OP_ADDP) ||
                     (ins.op == OP_MUL) || (ins.op == OP_WMUL) || (ins.op == OP_DIV) ||
                     (ins.op == OP_HALF) || (ins.op == OP_NEG) || (ins.op == OP_NEGP) ||
                     (ins.op == OP_PASS);

  // register readback
  always_comb begin
    case (cfg_idx)
      CFG_TC:  prdata = {1'b0, tc_q};
      CFG_SC:  prdata = {1'b0, sc_q};
      CFG_SS:  prdata = {1'b0, ss_q};
      CFG_UC:  prdata = {1'b0, uc_q};
      CFG_US:  prdata = {1'b0, us_q};
      CFG_WP:  prdata = {16'h0000, wp_q};
      CFG_WV:  prdata = {16'h0000, wv_q};
      default: prdata = {25'h0, ns_q};
    endcase
  end

  // reset image of the register file
  always_comb begin
    case (init_q)
      R_TC:    init_data = {1'b0, tc_q};
      R_SC:    init_data = {1'b0, sc_q};
      R_SS:    init_data = {1'b0, ss_q};
      R_UC:    init_data = {1'b0, uc_q};
      R_US:    init_data = {1'b0, us_q};
      R_WP:    init_data = {16'h0000, wp_q};
      R_WV:    init_data = {16'h0000, wv_q};
      R_SPY:   init_data = StartPosYReset;
      default: init_data = 32'sd0;
    endcase
  end

  always_comb begin
    case (ins.imm[1:0])
      2'd0:    in_field = in_q.step_length;
      2'd1:    in_field = in_q.step_width;
      2'd2:    in_field = in_q.next_length;
      default: in_field = in_q.next_width;
    endcase
  end

  // write port: APB first, then sequencer, then init sweep
  always_comb begin
    we = 1'b0;
    wa = init_q;
    wd = init_data;
    if (apb_we) begin
      we = (cfg_idx != CFG_NS);
      wa = {3'b000, cfg_idx};
      case (cfg_idx)
        CFG_WP, CFG_WV: wd = {16'h0000, pwdata[15:0]};
        default:        wd = {1'b0, pwdata[30:0]};
      endcase
    end else if (state_q == S_WAIT && alu_done) begin
      we = 1'b1;
      wa = ins.dst;
      wd = alu_res;
    end else if (state_q == S_EXEC && (ins.op == OP_IN || ins.op == OP_ONE)) begin
      we = 1'b1;
      wa = ins.dst;
      wd = (ins.op == OP_ONE) ? QOne : in_field;
    end else if (state_q == S_INIT) begin
      we = 1'b1;
    end
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH) begin
      rd_a_q <= mem[ins.a];
      rd_b_q <= mem[ins.b];
    end
  end

  assign alu_req.start  = (state_q == S_EXEC) && is_alu_op;
  assign alu_req.op     = ins.op;
  assign alu_req.parity = parity_q;

  lwps_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= 31'd18702;
      sc_q <= 31'd65682;
      ss_q <= 31'd7017;
      uc_q <= 31'd1129218;
      us_q <= 31'd1127318;
      wp_q <= 16'd10;
      wv_q <= 16'd1;
      ns_q <= 7'd41;
    end else if (apb_we) begin
      case (cfg_idx)
        CFG_TC:  tc_q <= pwdata[30:0];
        CFG_SC:  sc_q <= pwdata[30:0];
        CFG_SS:  ss_q <= pwdata[30:0];
        CFG_UC:  uc_q <= pwdata[30:0];
        CFG_US:  us_q <= pwdata[30:0];
        CFG_WP:  wp_q <= pwdata[15:0];
        CFG_WV:  wv_q <= pwdata[15:0];
        default: ns_q <= pwdata[6:0];
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      pc_q        <= '0;
      k_q         <= '0;
      n_q         <= 7'd1;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new load takes the slot the leaving transaction frees
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          if (!apb_we) begin
            init_q <= init_q + 6'd1;
            if (init_q == 6'd63) state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            pc_q    <= '0;
            k_q     <= '0;
            // clamp the sample count to 1..MaxSamples
            if (ns_q == 7'd0) n_q <= 7'd1;
            else if (ns_q > 7'(MaxSamples)) n_q <= 7'(MaxSamples);
            else n_q <= ns_q;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: state_q <= S_EXEC;
        S_EXEC: begin
          case (ins.op)
            OP_IN, OP_ONE: begin
              pc_q    <= pc_q + 7'd1;
              state_q <= S_FETCH;
            end
            OP_BRZ: begin
              pc_q    <= (k_q == 6'd0) ? ins.imm : pc_q + 7'd1;
              state_q <= S_FETCH;
            end
            OP_LOOP: begin
              if (!k_last) begin
                k_q  <= k_q + 6'd1;
                pc_q <= ins.imm;
              end else begin
                pc_q <= pc_q + 7'd1;
              end
              state_q <= S_FETCH;
            end
            OP_STAGE: begin
              stage_q[{ins.imm[0], 1'b0}] <= rd_a_q;
              stage_q[{ins.imm[0], 1'b1}] <= rd_b_q;
              pc_q    <= pc_q + 7'd1;
              state_q <= S_FETCH;
            end
            OP_EMIT: begin
              // the final sample goes out after the landing solve
              if (k_last) begin
                pc_q    <= pc_q + 7'd1;
                state_q <= S_FETCH;
              end else if (out_free) begin
                out_q       <= '{com_x: rd_a_q, com_y: rd_b_q, last_sample: 1'b0,
                                 foot_x: 32'sd0, foot_y: 32'sd0,
                                 landing_x: 32'sd0, landing_y: 32'sd0};
                pc_q        <= pc_q + 7'd1;
                state_q     <= S_FETCH;
              end
            end
            OP_LAST: begin
              if (out_free) begin
                out_q       <= '{com_x: rd_a_q, com_y: rd_b_q, last_sample: 1'b1,
                                 foot_x: stage_q[0], foot_y: stage_q[1],
                                 landing_x: stage_q[2], landing_y: stage_q[3]};
                parity_q    <= ~parity_q;
                state_q     <= S_IDLE;
              end
            end
            default: state_q <= S_WAIT;
          endcase
        end
        S_WAIT: begin
          if (alu_done) begin
            pc_q    <= pc_q + 7'd1;
            state_q <= S_FETCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a footstep keeps the block busy for at least the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // the arithmetic unit only reports completion while the sequencer waits on it
  `ASSERT_AT(a_done_in_wait, clk_i, rst_ni, !alu_done || state_q == S_WAIT)
  // the sample index stays below the clamped count
  `ASSERT_AT(a_k_in_range, clk_i, rst_ni, ({1'b0, k_q} < n_q) && (n_q != 7'd0))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for lip_walking_pattern_step_core: directed footsteps,
// then random phases under fresh register settings, checked by an in-file predictor.
// Depends on lwps_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
  import lwps_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lip_walking_pattern_step_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor copy of the registers and the gait state
  int tc_q, sc_q, ss_q, uc_q, us_q, wp_q, wv_q;
  int unsigned nsamp_q;
  int pos_x, pos_y, vel_x, vel_y, nom_x, nom_y, land_x, land_y;
  bit parity_q;

  out_item_t samples_due[$];
  int        errors;
  int        burst_left;
  bit        hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Q16.16 arithmetic, saturating
  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int qadd(int a, int b);
    return sat(longint'(a) + longint'(b));
  endfunction

  function automatic int qsub(int a, int b);
    return sat(longint'(a) - longint'(b));
  endfunction

  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return sat(p >>> 16);
  endfunction

  function automatic int qdiv(int n, int d);
    longint num, un, ud, q;
    bit neg;
    if (d == 0) return (n > 0) ? 32'h7FFF_FFFF : (n < 0) ? 32'h8000_0000 : 0;
    num = longint'(n) * 64'sd65536;
    neg = (num < 0) != (d < 0);
    un = (num < 0) ? -num : num;
    ud = (d < 0) ? -longint'(d) : longint'(d);
    q = (un + ud / 2) / ud;
    return neg ? sat(-q) : sat(q);
  endfunction

  function automatic int wmul(int w, int v);
    return sat(longint'(w) * longint'(v));
  endfunction

  // Optimal landing point from target state and end-of-support state
  function automatic int solve_landing(int target, int vtarget, int pos, int vel);
    int cm1, sot, tcs, den, g1, g2, ep, ev;
    cm1 = qsub(uc_q, 65536);
    sot = qdiv(us_q, tc_q);
    tcs = qmul(tc_q, us_q);
    den = qadd(wmul(wp_q, qmul(cm1, cm1)), wmul(wv_q, qmul(sot, sot)));
    g1 = qdiv(wmul(wp_q, cm1), den);
    g2 = qdiv(wmul(wv_q, sot), den);
    ep = qsub(qsub(target, qmul(uc_q, pos)), qmul(tcs, vel));
    ev = qsub(qsub(vtarget, qmul(sot, pos)), qmul(uc_q, vel));
    return qsub(sat(-longint'(qmul(g1, ep))), qmul(g2, ev));
  endfunction

  // Expected trajectory samples and foot points for one footstep
  task automatic predict_footstep(in_item_t it);
    int tcs, sot, rx, ry, vx, vy, nrx, nry, nvx, nvy, xb, yb, ks, kx, ky;
    int unsigned n;
    out_item_t o;
    n = (nsamp_q < 1) ? 1 : (nsamp_q > MaxSamples) ? MaxSamples : nsamp_q;
    tcs = qmul(tc_q, ss_q);
    sot = qdiv(ss_q, tc_q);
    rx = qsub(pos_x, land_x);
    ry = qsub(pos_y, land_y);
    vx = vel_x;
    vy = vel_y;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        nrx = qadd(qmul(sc_q, rx), qmul(tcs, vx));
        nry = qadd(qmul(sc_q, ry), qmul(tcs, vy));
        nvx = qadd(qmul(sot, rx), qmul(sc_q, vx));
        nvy = qadd(qmul(sot, ry), qmul(sc_q, vy));
        rx = nrx; ry = nry; vx = nvx; vy = nvy;
      end
      o = '0;
      o.com_x = qadd(rx, land_x);
      o.com_y = qadd(ry, land_y);
      pos_x = o.com_x;
      pos_y = o.com_y;
      if (k < n - 1) samples_due = {samples_due, o};
    end
    vel_x = vx;
    vel_y = vy;
    nom_x = qadd(nom_x, it.step_length);
    nom_y = parity_q ? qsub(nom_y, it.step_width) : qadd(nom_y, it.step_width);
    xb = it.next_length >>> 1;
    yb = parity_q ? (it.next_width >>> 1) : sat(-longint'(it.next_width >>> 1));
    ks = qmul(tc_q, us_q);
    kx = qdiv(qadd(uc_q, 65536), ks);
    ky = qdiv(qsub(uc_q, 65536), ks);
    land_x = solve_landing(qadd(nom_x, xb), qmul(kx, xb), pos_x, vel_x);
    land_y = solve_landing(qadd(nom_y, yb), qmul(ky, yb), pos_y, vel_y);
    o.last_sample = 1'b1;
    o.foot_x = nom_x;
    o.foot_y = nom_y;
    o.landing_x = land_x;
    o.landing_y = land_y;
    samples_due = {samples_due, o};
    parity_q = ~parity_q;
  endtask

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (samples_due.size() == 0) begin
        flag_mismatch("unexpected transaction", 1, 0);
      end else begin
        out_item_t w;
        w = samples_due.pop_front();
        if (out_data_o.com_x !== w.com_x) flag_mismatch("com_x", out_data_o.com_x, w.com_x);
        if (out_data_o.com_y !== w.com_y) flag_mismatch("com_y", out_data_o.com_y, w.com_y);
        if (out_data_o.last_sample !== w.last_sample)
          flag_mismatch("last_sample", out_data_o.last_sample, w.last_sample);
        if (out_data_o.foot_x !== w.foot_x) flag_mismatch("foot_x", out_data_o.foot_x, w.foot_x);
        if (out_data_o.foot_y !== w.foot_y) flag_mismatch("foot_y", out_data_o.foot_y, w.foot_y);
        if (out_data_o.landing_x !== w.landing_x)
          flag_mismatch("landing_x", out_data_o.landing_x, w.landing_x);
        if (out_data_o.landing_y !== w.landing_y)
          flag_mismatch("landing_y", out_data_o.landing_y, w.landing_y);
      end
    end
  end

  // Receiver: stall pattern changes every so often, plus one long hold-off on request
  initial begin
    int mode, left, held;
    mode = 0;
    left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (held = 0; held < 3000; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= ($urandom_range(0, 9) == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // APB register write, also updating the predictor copy
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      CFG_TC: tc_q = int'(val & 32'h7FFF_FFFF);
      CFG_SC: sc_q = int'(val & 32'h7FFF_FFFF);
      CFG_SS: ss_q = int'(val & 32'h7FFF_FFFF);
      CFG_UC: uc_q = int'(val & 32'h7FFF_FFFF);
      CFG_US: us_q = int'(val & 32'h7FFF_FFFF);
      CFG_WP: wp_q = int'(val & 32'hFFFF);
      CFG_WV: wv_q = int'(val & 32'hFFFF);
      default: nsamp_q = val & 32'h7F;
    endcase
  endtask

  // Stop offering, wait for all samples, then let the sequencer settle
  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    wait (samples_due.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  // Offer one footstep in bursts with gaps; predict on acceptance
  task automatic send_step(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_footstep(it);
  endtask

  function automatic in_item_t walk_step();
    in_item_t it;
    it.step_length = $urandom_range(0, 52428) - 26214;
    it.step_width  = $urandom_range(0, 26214) - 13107;
    it.next_length = $urandom_range(0, 1) ? 0 : $urandom_range(0, 52428) - 26214;
    it.next_width  = $urandom_range(0, 26214) - 13107;
    return it;
  endfunction

  function automatic in_item_t noise_step();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic logic [31:0] edge_val(logic [31:0] top);
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return top;
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    bit          cfg_en;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_val;
    in_item_t    it;
    bit          chk;
    int          first_x;
    int          first_y;
  } step_row_t;

  localparam int QM = 32'h7FFF_FFFF;
  localparam int QN = 32'h8000_0000;

  // Directed footsteps; first row checks the start state left by reset
  step_row_t steps_tbl[] = '{
    '{0, CFG_TC, 0, '{13107, 13107, 13107, 13107}, 1, 0, 655},
    '{0, CFG_TC, 0, '{QM, QM, QM, QM}, 0, 0, 0},
    '{0, CFG_TC, 0, '{QN, QN, QN, QN}, 0, 0, 0},
    '{0, CFG_TC, 0, '{0, 0, 0, 0}, 0, 0, 0},
    '{0, CFG_TC, 0, '{-1, 1, -1, 1}, 0, 0, 0},
    '{1, CFG_NS, 1, '{13107, -13107, 13107, -13107}, 0, 0, 0},
    '{1, CFG_NS, 0, '{6553, 6553, 0, 0}, 0, 0, 0},
    '{1, CFG_NS, 127, '{6553, 6553, 6553, 6553}, 0, 0, 0},
    '{1, CFG_NS, 64, '{QN, QM, QN, QM}, 0, 0, 0},
    '{1, CFG_NS, 3, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_TC, 0, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_TC, 32'h7FFF_FFFF, '{13107, -13107, 0, 0}, 0, 0, 0},
    '{1, CFG_TC, 18702, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_WP, 0, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_WV, 0, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_WP, 32'hFFFF, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_WV, 32'hFFFF, '{-13107, 13107, 0, 13107}, 0, 0, 0},
    '{1, CFG_SC, 32'h7FFF_FFFF, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_SS, 32'h7FFF_FFFF, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_UC, 65536, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_US, 0, '{13107, 13107, 13107, 13107}, 0, 0, 0},
    '{1, CFG_UC, 32'h7FFF_FFFF, '{QM, QN, QM, QN}, 0, 0, 0},
    '{1, CFG_US, 32'h7FFF_FFFF, '{13107, 13107, 13107, 13107}, 0, 0, 0}
  };

  // Main stimulus
  initial begin
    int sent, phase, count;
    bit wild;
    errors = 0;
    burst_left = 0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0;
    tc_q = 18702; sc_q = 65682; ss_q = 7017; uc_q = 1129218; us_q = 1127318;
    wp_q = 10; wv_q = 1; nsamp_q = 41;
    pos_x = 0; pos_y = 655; vel_x = 0; vel_y = 0;
    nom_x = 0; nom_y = 0; land_x = 0; land_y = 0; parity_q = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // register file load pass after reset
    repeat (100) @(posedge clk_i);

    foreach (steps_tbl[r]) begin
      if (steps_tbl[r].cfg_en) begin
        drain();
        write_reg(steps_tbl[r].cfg_idx, steps_tbl[r].cfg_val);
      end
      send_step(steps_tbl[r].it);
      if (steps_tbl[r].chk) begin
        samples_due[0].com_x = steps_tbl[r].first_x;
        samples_due[0].com_y = steps_tbl[r].first_y;
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 340) begin
      drain();
      wild = (phase % 5 == 4);
      if (wild) begin
        write_reg(CFG_TC, edge_val(32'h7FFF_FFFF));
        write_reg(CFG_SC, edge_val(32'h7FFF_FFFF));
        write_reg(CFG_SS, edge_val(32'h7FFF_FFFF));
        write_reg(CFG_UC, edge_val(32'h7FFF_FFFF));
        write_reg(CFG_US, edge_val(32'h7FFF_FFFF));
        write_reg(CFG_WP, edge_val(32'hFFFF));
        write_reg(CFG_WV, edge_val(32'hFFFF));
        write_reg(CFG_NS, edge_val(32'h7F));
      end else begin
        write_reg(CFG_TC, $urandom_range(12000, 26000));
        write_reg(CFG_SC, $urandom_range(65536, 66000));
        write_reg(CFG_SS, $urandom_range(0, 9000));
        write_reg(CFG_UC, $urandom_range(65536, 1200000));
        write_reg(CFG_US, $urandom_range(0, 1200000));
        write_reg(CFG_WP, $urandom_range(0, 20));
        write_reg(CFG_WV, $urandom_range(0, 5));
        write_reg(CFG_NS, (phase == 7) ? 64 : $urandom_range(1, 6));
      end
      // one long receiver hold-off while footsteps keep coming
      if (phase == 1) hold_req = 1'b1;
      for (count = 0; count < (wild || phase == 7 ? 4 : 24); count++) begin
        send_step(($urandom_range(0, 3) == 0) ? noise_step() : walk_step());
        sent++;
      end
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lwps_pkg.sv
rtl/core/lwps_alu.sv
rtl/core/lip_walking_pattern_step_core.sv
tb/sv/tb_top.sv
